// ===== rtl/core/lli_pkg.sv =====
// Package: payload types, widths and shared constants for the line intersection block.
package lli_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int EpsWidth   = 16;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int MagWidth   = CrossWidth - 1;
  localparam int NumWidth   = MagWidth + FracBits;
  localparam int QuotWidth  = NumWidth;
  localparam int DivStages  = NumWidth;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  typedef struct packed {
    logic signed [CoordWidth-1:0] first_start_x;
    logic signed [CoordWidth-1:0] first_start_y;
    logic signed [CoordWidth-1:0] first_end_x;
    logic signed [CoordWidth-1:0] first_end_y;
    logic signed [CoordWidth-1:0] second_start_x;
    logic signed [CoordWidth-1:0] second_start_y;
    logic signed [CoordWidth-1:0] second_end_x;
    logic signed [CoordWidth-1:0] second_end_y;
  } lli_req_t;

  typedef struct packed {
    logic                         intersects;
    logic                         collinear;
    logic signed [CoordWidth-1:0] alpha;
    logic signed [CoordWidth-1:0] beta;
  } lli_res_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                intersects;
    logic                collinear;
    logic                alpha_en;
    logic                beta_en;
    logic                alpha_neg;
    logic                beta_neg;
    logic [MagWidth-1:0] alpha_num;
    logic [MagWidth-1:0] beta_num;
    logic [MagWidth-1:0] den;
  } lli_job_t;

  // Divider lane carried along the pipeline
  typedef struct packed {
    logic                 en;
    logic                 neg;
    logic [NumWidth-1:0]  num;
    logic [NumWidth:0]    rem;
    logic [QuotWidth-1:0] quot;
  } lli_lane_t;

endpackage

// ===== rtl/core/lli_front.sv =====
// Front end: differences, cross products, threshold tests, classification.
module lli_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  lli_pkg::lli_req_t          req,
  input  logic [lli_pkg::EpsWidth-1:0] epsilon,
  output logic                       job_valid,
  output lli_pkg::lli_job_t          job
);
  import lli_pkg::*;

  // Stage 1: differences
  logic                         s1_valid;
  logic signed [DiffWidth-1:0]  rx, ry, sx, sy, tx, ty;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_valid;
    rx <= DiffWidth'(req.first_end_x)  - DiffWidth'(req.first_start_x);
    ry <= DiffWidth'(req.first_end_y)  - DiffWidth'(req.first_start_y);
    sx <= DiffWidth'(req.second_end_x) - DiffWidth'(req.second_start_x);
    sy <= DiffWidth'(req.second_end_y) - DiffWidth'(req.second_start_y);
    tx <= DiffWidth'(req.second_start_x) - DiffWidth'(req.first_start_x);
    ty <= DiffWidth'(req.second_start_y) - DiffWidth'(req.first_start_y);
  end

  // Stage 2: products, one multiplier per register
  logic                         s2_valid;
  logic signed [ProdWidth-1:0]  p_rxsy, p_rysx, p_rxty, p_rytx, p_txsy, p_tysx, p_txry, p_tyrx;
  logic                         r_big, s_big;
  logic [DiffWidth-1:0]         arx, ary, asx, asy;

  always_comb begin
    arx = rx[DiffWidth-1] ? DiffWidth'(-rx) : rx;
    ary = ry[DiffWidth-1] ? DiffWidth'(-ry) : ry;
    asx = sx[DiffWidth-1] ? DiffWidth'(-sx) : sx;
    asy = sy[DiffWidth-1] ? DiffWidth'(-sy) : sy;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    p_rxsy <= rx * sy;
    p_rysx <= ry * sx;
    p_rxty <= rx * ty;
    p_rytx <= ry * tx;
    p_txsy <= tx * sy;
    p_tysx <= ty * sx;
    p_txry <= tx * ry;
    p_tyrx <= ty * rx;
    r_big  <= (arx > DiffWidth'(epsilon)) || (ary > DiffWidth'(epsilon));
    s_big  <= (asx > DiffWidth'(epsilon)) || (asy > DiffWidth'(epsilon));
  end

  // Stage 3: cross products and classification
  logic signed [CrossWidth-1:0] d, c, na, nb;
  logic [MagWidth-1:0]          ad, ac, ana, anb, thr;
  logic                         parallel;

  always_comb begin
    d   = CrossWidth'(p_rxsy) - CrossWidth'(p_rysx);
    c   = CrossWidth'(p_rxty) - CrossWidth'(p_rytx);
    na  = CrossWidth'(p_txsy) - CrossWidth'(p_tysx);
    nb  = CrossWidth'(p_txry) - CrossWidth'(p_tyrx);
    ad  = MagWidth'(d[CrossWidth-1]  ? -d  : d);
    ac  = MagWidth'(c[CrossWidth-1]  ? -c  : c);
    ana = MagWidth'(na[CrossWidth-1] ? -na : na);
    anb = MagWidth'(nb[CrossWidth-1] ? -nb : nb);
    thr = MagWidth'({epsilon, {FracBits{1'b0}}});
    parallel = (ad < thr) || (ad == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) job_valid <= 1'b0;
    else     job_valid <= s2_valid;
    job.intersects <= !parallel;
    job.collinear  <= parallel && (ac < thr);
    job.alpha_en   <= !parallel && r_big;
    job.beta_en    <= !parallel && s_big;
    job.alpha_neg  <= na[CrossWidth-1] ^ d[CrossWidth-1];
    job.beta_neg   <= nb[CrossWidth-1] ^ d[CrossWidth-1];
    job.alpha_num  <= ana;
    job.beta_num   <= anb;
    job.den        <= ad;
  end

  // Checks
  ap_collinear_parallel: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> !(job.collinear && job.intersects)) else $error("collinear and intersects");
  ap_en_needs_hit: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job.intersects |-> !job.alpha_en && !job.beta_en)
    else $error("quotient enabled on parallel lines");
  ap_pipe: assert property (@(posedge clk) disable iff (rst)
    s2_valid |=> job_valid) else $error("front pipeline lost a request");
endmodule

// ===== rtl/core/lli_queue.sv =====
// Short FIFO between front and back ends.
module lli_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lli_pkg::lli_job_t push_data,
  input  logic              pop,
  output logic              not_empty,
  output lli_pkg::lli_job_t pop_data
);
  import lli_pkg::*;

  lli_job_t            mem [QueueDepth];
  logic [QueuePtrW-1:0] wptr, rptr;
  logic [QueuePtrW:0]   count;

  assign not_empty = (count != '0);
  assign pop_data  = mem[rptr];

  // Pointer and storage update
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
    if (push) mem[wptr] <= push_data;
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == (QueuePtrW+1)'(QueueDepth))) else $error("queue overflow");
  ap_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("queue underflow");
  ap_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("count mismatch");
endmodule

// ===== rtl/core/lli_back.sv =====
// Back end: two pipelined restoring dividers with saturation.
module lli_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  lli_pkg::lli_job_t job,
  output logic              done,
  output lli_pkg::lli_res_t res
);
  import lli_pkg::*;

  localparam int PipeLen = DivStages + 1;

  logic                      v   [PipeLen];
  logic                      hit [PipeLen];
  logic                      col [PipeLen];
  logic [MagWidth-1:0]       den [PipeLen];
  lli_lane_t                 la  [PipeLen];
  lli_lane_t                 lb  [PipeLen];

  function automatic lli_lane_t div_step(lli_lane_t x, logic [MagWidth-1:0] dv);
    logic [NumWidth:0] r;
    lli_lane_t         y;
    y = x;
    r = {x.rem[NumWidth-1:0], x.num[NumWidth-1]};
    y.num = {x.num[NumWidth-2:0], 1'b0};
    if (r >= (NumWidth+1)'(dv)) begin
      y.rem  = r - (NumWidth+1)'(dv);
      y.quot = {x.quot[QuotWidth-2:0], 1'b1};
    end else begin
      y.rem  = r;
      y.quot = {x.quot[QuotWidth-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [CoordWidth-1:0] sat(lli_lane_t x);
    logic [QuotWidth-1:0] lim;
    logic [QuotWidth-1:0] m;
    lim = x.neg ? QuotWidth'({1'b1, {(CoordWidth-1){1'b0}}})
                : QuotWidth'({(CoordWidth-1){1'b1}});
    m = (x.quot > lim) ? lim : x.quot;
    if (!x.en) return '0;
    return x.neg ? CoordWidth'(-m) : CoordWidth'(m);
  endfunction

  // Stage 0 load
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= job_valid;
    hit[0] <= job.intersects;
    col[0] <= job.collinear;
    den[0] <= job.den;
    la[0]  <= '{en: job.alpha_en, neg: job.alpha_neg,
                num: {job.alpha_num, {FracBits{1'b0}}}, rem: '0, quot: '0};
    lb[0]  <= '{en: job.beta_en, neg: job.beta_neg,
                num: {job.beta_num, {FracBits{1'b0}}}, rem: '0, quot: '0};
  end

  // One quotient bit per stage
  for (genvar g = 1; g < PipeLen; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) v[g] <= 1'b0;
      else     v[g] <= v[g-1];
      hit[g] <= hit[g-1];
      col[g] <= col[g-1];
      den[g] <= den[g-1];
      la[g]  <= div_step(la[g-1], den[g-1]);
      lb[g]  <= div_step(lb[g-1], den[g-1]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v[PipeLen-1];
    res.intersects <= hit[PipeLen-1];
    res.collinear  <= col[PipeLen-1];
    res.alpha      <= sat(la[PipeLen-1]);
    res.beta       <= sat(lb[PipeLen-1]);
  end

  ap_flow: assert property (@(posedge clk) disable iff (rst)
    v[PipeLen-1] |=> done) else $error("back pipeline lost a request");
  ap_zero_when_parallel: assert property (@(posedge clk) disable iff (rst)
    done && !res.intersects |-> res.alpha == '0 && res.beta == '0)
    else $error("nonzero parameter on parallel lines");
  ap_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(res.intersects && res.collinear)) else $error("flag conflict");
endmodule

// ===== rtl/core/line_line_intersection.sv =====
// Top level: two-line intersection in signed Q16.16 fixed point.
//
// Usage: drive a request on req and pulse start; it is taken at any edge with
// start high and busy low. busy stays low in normal use, so a new request may
// enter every cycle. Each request yields exactly one result on res, marked by
// a one-cycle done strobe; results come back in request order.
// Pipeline: 3 front stages (differences, products, cross products and tests),
// then the queue, then 1 load + 82 quotient stages + 1 output register.
// Throughput: one request per cycle; the two dividers each resolve one
// quotient bit per stage.
// The receiver cannot stall, so the back end never holds off the queue.
// epsilon is written through cfg_we/cfg_data; the user must write it only
// while idle, which the block itself does not enforce; reset sets it to 66.
// Reset is synchronous and clears all valid flags and the queue.
module line_line_intersection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lli_pkg::lli_req_t             req,
  input  logic                          cfg_we,
  input  logic [lli_pkg::EpsWidth-1:0]  cfg_data,
  output logic                          done,
  output lli_pkg::lli_res_t             res
);
  import lli_pkg::*;

  localparam logic [EpsWidth-1:0] EpsReset = EpsWidth'(66);

  logic [EpsWidth-1:0] epsilon;
  logic                fj_valid, q_ne;
  lli_job_t            fj, qj;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst)         epsilon <= EpsReset;
    else if (cfg_we) epsilon <= cfg_data;
  end

  assign busy = 1'b0;

  lli_front u_front (.clk, .rst, .in_valid(start && !busy), .req, .epsilon,
                     .job_valid(fj_valid), .job(fj));

  lli_queue u_queue (.clk, .rst, .push(fj_valid), .push_data(fj),
                     .pop(q_ne), .not_empty(q_ne), .pop_data(qj));

  lli_back u_back (.clk, .rst, .job_valid(q_ne), .job(qj), .done, .res);
endmodule

// ===== tb/sv/lli_checker.sv =====
// Checker: predicts line intersection results and compares them with the block output.
`timescale 1ns / 100ps
module lli_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  lli_pkg::lli_req_t req,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              done,
  input  lli_pkg::lli_res_t res,
  output int                fail_count,
  output int                pending
);
  import lli_pkg::*;

  lli_res_t   expected_q[$];
  logic [15:0] eps_shadow;

  // exact signed cross product a x b
  function automatic logic signed [127:0] cross2(logic signed [127:0] ax,
      logic signed [127:0] ay, logic signed [127:0] bx, logic signed [127:0] by);
    cross2 = ax * by - ay * bx;
  endfunction

  function automatic logic signed [127:0] abs128(logic signed [127:0] v);
    abs128 = (v < 0) ? -v : v;
  endfunction

  // (num << 16) / den, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] sat_quot(logic signed [127:0] num,
      logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FracBits) / den;
    if (q > 128'sd2147483647) sat_quot = 32'h7fffffff;
    else if (q < -128'sd2147483648) sat_quot = 32'h80000000;
    else sat_quot = q[31:0];
  endfunction

  function automatic lli_res_t predict_intersection(lli_req_t r, logic [15:0] eps);
    logic signed [127:0] rx, ry, sx, sy, tx, ty, d, thr, c, e;
    lli_res_t o;
    rx = $signed(r.first_end_x) - $signed(r.first_start_x);
    ry = $signed(r.first_end_y) - $signed(r.first_start_y);
    sx = $signed(r.second_end_x) - $signed(r.second_start_x);
    sy = $signed(r.second_end_y) - $signed(r.second_start_y);
    tx = $signed(r.second_start_x) - $signed(r.first_start_x);
    ty = $signed(r.second_start_y) - $signed(r.first_start_y);
    thr = {96'd0, eps, 16'd0};
    e = {112'd0, eps};
    d = cross2(rx, ry, sx, sy);
    o = '0;
    if (abs128(d) < thr || d == 0) begin
      c = cross2(rx, ry, tx, ty);
      o.collinear = abs128(c) < thr;
    end else begin
      o.intersects = 1'b1;
      if (abs128(rx) > e || abs128(ry) > e) o.alpha = sat_quot(cross2(tx, ty, sx, sy), d);
      if (abs128(sx) > e || abs128(sy) > e) o.beta = sat_quot(cross2(tx, ty, rx, ry), d);
    end
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    lli_res_t exp_res;
    if (rst) begin
      eps_shadow <= 16'd66;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) eps_shadow <= cfg_data;
      if (start && !busy) expected_q.push_back(predict_intersection(req, eps_shadow));
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_q.pop_front();
          if (res.intersects !== exp_res.intersects || res.collinear !== exp_res.collinear ||
              res.alpha !== exp_res.alpha || res.beta !== exp_res.beta) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_res, res);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives line pair requests and epsilon settings, reports the verdict.
`timescale 1ns / 100ps
module tb;
  import lli_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  lli_req_t    req = '0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        done;
  lli_res_t    res;
  int          fail_count;
  int          pending;
  int          cycle_cnt = 0;

  always #1 clk = ~clk;

  line_line_intersection u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .res(res)
  );

  lli_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .res(res),
    .fail_count(fail_count), .pending(pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("line_line_intersection test failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: rand_coord = $urandom;
      1: rand_coord = $urandom_range(0, 32'h000fffff) - 32'h00080000;
      2: rand_coord = $urandom_range(0, 32'h3ff) - 32'h200;
      default: rand_coord = $urandom_range(0, 32'h7fffff) - 32'h400000;
    endcase
  endfunction

  // random pair: general, parallel, collinear, degenerate or tiny
  function automatic lli_req_t rand_pair();
    lli_req_t r;
    int mode, kind;
    logic [31:0] dx, dy, k;
    mode = $urandom_range(0, 3);
    kind = $urandom_range(0, 9);
    r.first_start_x = rand_coord(mode); r.first_start_y = rand_coord(mode);
    r.first_end_x = rand_coord(mode);   r.first_end_y = rand_coord(mode);
    r.second_start_x = rand_coord(mode); r.second_start_y = rand_coord(mode);
    r.second_end_x = rand_coord(mode);  r.second_end_y = rand_coord(mode);
    dx = r.first_end_x - r.first_start_x;
    dy = r.first_end_y - r.first_start_y;
    k = $urandom_range(0, 3) - 1;
    if (kind == 0 || kind == 1) begin
      r.second_end_x = r.second_start_x + dx * k + $urandom_range(0, 1);
      r.second_end_y = r.second_start_y + dy * k;
    end
    if (kind == 1 || kind == 2) begin
      r.second_start_x = r.first_start_x + dx * k;
      r.second_start_y = r.first_start_y + dy * k + $urandom_range(0, 1);
      r.second_end_x = r.second_start_x + dx;
      r.second_end_y = r.second_start_y + dy;
    end
    if (kind == 3) begin
      r.first_end_x = r.first_start_x + $urandom_range(0, 64) - 32;
      r.first_end_y = r.first_start_y + $urandom_range(0, 64) - 32;
    end
    if (kind == 4) begin
      r.second_end_x = r.second_start_x + $urandom_range(0, 64) - 32;
      r.second_end_y = r.second_start_y + $urandom_range(0, 64) - 32;
    end
    return r;
  endfunction

  task automatic send_request(lli_req_t r);
    req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_line(logic [31:0] a, b, c, d, e, f, g, h);
    lli_req_t r;
    r = {a, b, c, d, e, f, g, h};
    send_request(r);
  endtask

  initial begin
    logic [15:0] eps_set[5];
    int burst;
    eps_set = '{16'd0, 16'hffff, 16'd1, 16'd66, 16'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset epsilon, crossing, parallel, collinear, extremes, degenerate
    send_line(0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 32'h10000, 0);
    send_line(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000);
    send_line(0, 0, 32'h10000, 0, 32'h20000, 0, 32'h30000, 0);
    send_line(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_line(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              0, 0, 1, 32'h7fffffff);
    send_line(5, 5, 6, 5, 0, 0, 32'h7fffffff, 32'h80000000);
    send_line(0, 0, 32'h7fffffff, 1, 5, 5, 6, 6);
    send_line(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0);
    send_line(0, 0, 1, 0, 0, 0, 0, 1);
    send_line(0, 0, 32'h7fffffff, 0, 0, 1, 32'h80000000, 32'h7fffffff);
    send_line(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
              32'h12345678, 32'hedcba987, 32'h0f0f0f0f, 32'hf0f0f0f0);
    drain_block();

    // random phases over several epsilon settings
    for (int ph = 0; ph < 5; ph++) begin
      write_epsilon(eps_set[ph]);
      for (int n = 0; n < 260;) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst && n < 260; b++, n++) send_request(rand_pair());
        start <= 1'b0;
        if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(posedge clk);
        else @(posedge clk);
      end
      drain_block();
    end

    if (fail_count == 0) begin
      $display("line_line_intersection test passed");
    end else begin
      $display("line_line_intersection test failed");
    end
    $finish;
  end
endmodule
